// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the text cleaner modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define UTC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define UTC_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define UTC_ASSERT(label, clk, rst_n, prop)
`define UTC_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== sv/utc_pkg.sv =====
// ---------------------------------------------------------------------------
// Text cleaner package
// Types, constants, code point classification and encoding shared by the cleaner modules.
// ---------------------------------------------------------------------------
package utc_pkg;

    localparam int UTC_FIFO_DEPTH = 4;
    localparam int UTC_MAX_BYTES  = 5;

    localparam logic [7:0]  SPACE_BYTE = 8'h20;
    localparam logic [20:0] CP_MAX     = 21'h10FFFF;

    typedef struct packed {
        logic [UTC_MAX_BYTES-1:0][7:0] data;
        logic [2:0]                    last;
        logic                          bv;
        logic                          fin;
    } t_job;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      len;
    } t_enc;

    function automatic logic in_rng(logic [20:0] c, logic [20:0] lo, logic [20:0] hi);
        return (c >= lo) && (c <= hi);
    endfunction

    function automatic logic cp_is_ws(logic [20:0] c);
        return c == 21'h20 || in_rng(c, 21'h09, 21'h0D) || in_rng(c, 21'h1C, 21'h1E) ||
               c == 21'h85 || c == 21'hA0 || c == 21'h1680 ||
               in_rng(c, 21'h2000, 21'h200A) || c == 21'h2028 || c == 21'h2029 ||
               c == 21'h202F || c == 21'h205F || c == 21'h3000;
    endfunction

    function automatic logic cp_is_break(logic [20:0] c);
        return in_rng(c, 21'h0A, 21'h0D) || in_rng(c, 21'h1C, 21'h1E) ||
               c == 21'h85 || c == 21'h2028 || c == 21'h2029;
    endfunction

    function automatic logic cp_is_dropped(logic [20:0] c);
        return c <= 21'h1F || in_rng(c, 21'h7F, 21'h9F) ||
               in_rng(c, 21'hD800, 21'hDFFF) || in_rng(c, 21'hE000, 21'hF8FF) ||
               in_rng(c, 21'hF0000, 21'hFFFFD) || in_rng(c, 21'h100000, 21'h10FFFD) ||
               c == 21'hAD || in_rng(c, 21'h200B, 21'h200F) || c == 21'hFEFF;
    endfunction

    function automatic logic cp_is_cjk(logic [20:0] c);
        return in_rng(c, 21'h1100, 21'h11FF) || in_rng(c, 21'h2E80, 21'h2FDF) ||
               in_rng(c, 21'h3000, 21'h31FF) || in_rng(c, 21'h3400, 21'h4DBF) ||
               in_rng(c, 21'h4E00, 21'h9FFF) || in_rng(c, 21'hA960, 21'hA97F) ||
               in_rng(c, 21'hAC00, 21'hD7A3) || in_rng(c, 21'hD7B0, 21'hD7FF) ||
               in_rng(c, 21'hF900, 21'hFAFF) || in_rng(c, 21'hFE30, 21'hFE4F) ||
               in_rng(c, 21'hFF01, 21'hFF9F) || in_rng(c, 21'h20000, 21'h2FA1F);
    endfunction

    function automatic t_enc cp_encode(logic [20:0] c);
        t_enc e;
        e = '0;
        if (c <= 21'h7F) begin
            e.b[0] = c[7:0];
            e.len  = 3'd1;
        end else if (c <= 21'h7FF) begin
            e.b[0] = {3'b110, c[10:6]};
            e.b[1] = {2'b10, c[5:0]};
            e.len  = 3'd2;
        end else if (c <= 21'hFFFF) begin
            e.b[0] = {4'b1110, c[15:12]};
            e.b[1] = {2'b10, c[11:6]};
            e.b[2] = {2'b10, c[5:0]};
            e.len  = 3'd3;
        end else if (c <= CP_MAX) begin
            e.b[0] = {5'b11110, c[20:18]};
            e.b[1] = {2'b10, c[17:12]};
            e.b[2] = {2'b10, c[11:6]};
            e.b[3] = {2'b10, c[5:0]};
            e.len  = 3'd4;
        end
        return e;
    endfunction

endpackage

// ===== sv/utc_front.sv =====
// ---------------------------------------------------------------------------
// Text cleaner front end
// Decodes bytes into code points, classifies them and builds output jobs.
// ---------------------------------------------------------------------------
module utc_front
    import utc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_in_byte,
    input  logic       i_is_final,
    output logic       o_push,
    output t_job       o_job
);

    logic [1:0]  r_rem, n_rem;
    logic [20:0] r_acc, n_acc;
    logic        r_pend, n_pend;
    logic        r_brk, n_brk;
    logic        r_pcjk, n_pcjk;
    logic        r_seen, n_seen;

    logic        have;
    logic [20:0] cp;
    logic        is_ws, keep, cjk, space;
    t_enc        enc;
    logic [2:0]  cnt;

    always_comb begin
        have  = 1'b0;
        cp    = '0;
        n_rem = r_rem;
        n_acc = r_acc;
        if (r_rem == 2'd0) begin
            if (!i_in_byte[7]) begin
                have = 1'b1;
                cp   = {13'd0, i_in_byte};
            end else if (i_in_byte[7:5] == 3'b110) begin
                n_acc = {16'd0, i_in_byte[4:0]};
                n_rem = 2'd1;
            end else if (i_in_byte[7:4] == 4'b1110) begin
                n_acc = {17'd0, i_in_byte[3:0]};
                n_rem = 2'd2;
            end else if (i_in_byte[7:3] == 5'b11110) begin
                n_acc = {18'd0, i_in_byte[2:0]};
                n_rem = 2'd3;
            end
        end else begin
            n_acc = {r_acc[14:0], i_in_byte[5:0]};
            n_rem = r_rem - 2'd1;
            if (r_rem == 2'd1) begin
                have = 1'b1;
                cp   = n_acc;
            end
        end
    end

    always_comb begin
        is_ws = cp_is_ws(cp);
        keep  = have && !is_ws && !cp_is_dropped(cp);
        cjk   = cp_is_cjk(cp);
        space = keep && r_pend && !(r_brk && r_pcjk && cjk);
        enc   = cp_encode(cp);
        cnt   = {2'd0, space} + (keep ? enc.len : 3'd0);

        n_pend = r_pend;
        n_brk  = r_brk;
        n_pcjk = r_pcjk;
        n_seen = r_seen;
        if (have && is_ws && r_seen) begin
            n_pend = 1'b1;
            n_brk  = r_brk | cp_is_break(cp);
        end
        if (keep) begin
            n_pcjk = cjk;
            n_seen = 1'b1;
            n_pend = 1'b0;
            n_brk  = 1'b0;
        end
    end

    always_comb begin
        o_job = '0;
        if (space) begin
            o_job.data[0] = SPACE_BYTE;
            for (int i = 1; i < UTC_MAX_BYTES; i++) begin
                o_job.data[i] = enc.b[i-1];
            end
        end else if (keep) begin
            for (int i = 0; i < UTC_MAX_BYTES - 1; i++) begin
                o_job.data[i] = enc.b[i];
            end
        end
        o_job.last = (cnt == 3'd0) ? 3'd0 : cnt - 3'd1;
        o_job.bv   = (cnt != 3'd0);
        o_job.fin  = i_is_final;
        o_push     = i_accept && ((cnt != 3'd0) || i_is_final);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= '0;
            r_acc  <= '0;
            r_pend <= 1'b0;
            r_brk  <= 1'b0;
            r_pcjk <= 1'b0;
            r_seen <= 1'b0;
        end else if (i_accept) begin
            if (i_is_final) begin
                r_rem  <= '0;
                r_acc  <= '0;
                r_pend <= 1'b0;
                r_brk  <= 1'b0;
                r_pcjk <= 1'b0;
                r_seen <= 1'b0;
            end else begin
                r_rem  <= n_rem;
                r_acc  <= n_acc;
                r_pend <= n_pend;
                r_brk  <= n_brk;
                r_pcjk <= n_pcjk;
                r_seen <= n_seen;
            end
        end
    end

endmodule

// ===== sv/utc_fifo.sv =====
// ---------------------------------------------------------------------------
// Text cleaner job queue
// Short queue of output jobs between the front end and the back end.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module utc_fifo
    import utc_pkg::*;
#(
    parameter int DEPTH = UTC_FIFO_DEPTH
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    input  logic i_pop,
    output t_job o_data,
    output logic o_full,
    output logic o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    `UTC_NEVER(a_push_full, i_clk, i_rst_n, i_push && o_full && !i_pop)
    `UTC_NEVER(a_pop_empty, i_clk, i_rst_n, i_pop && o_empty)
    `UTC_ASSERT(a_count_up, i_clk, i_rst_n, (i_push && !i_pop) |=> (r_count == $past(r_count) + CW'(1)))

endmodule

// ===== sv/utc_back.sv =====
// ---------------------------------------------------------------------------
// Text cleaner back end
// Serializes queued jobs into output items, one byte per cycle while the receiver does not stall.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module utc_back
    import utc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_job       i_job,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_run_end,
    output logic       o_text_end
);

    t_job       r_job;
    logic [2:0] r_idx;
    logic       r_busy;
    logic       take, last;

    assign last    = (r_idx == r_job.last);
    assign take    = r_busy && !i_stall;
    assign o_pop   = !i_empty && (!r_busy || (take && last));
    assign o_valid = r_busy;

    always_comb begin
        case (r_idx)
            3'd0:    o_out_byte = r_job.data[0];
            3'd1:    o_out_byte = r_job.data[1];
            3'd2:    o_out_byte = r_job.data[2];
            3'd3:    o_out_byte = r_job.data[3];
            3'd4:    o_out_byte = r_job.data[4];
            default: o_out_byte = 8'd0;
        endcase
        o_byte_valid = r_job.bv;
        o_run_end    = last;
        o_text_end   = last && r_job.fin;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (take) begin
            if (last) begin
                r_busy <= 1'b0;
                r_idx  <= '0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    `UTC_ASSERT(a_text_end_run, i_clk, i_rst_n, (o_valid && o_text_end) |-> o_run_end)
    `UTC_ASSERT(a_bare_marker, i_clk, i_rst_n, (o_valid && !o_byte_valid) |-> (o_text_end && r_idx == 3'd0))
    `UTC_NEVER(a_idx_range, i_clk, i_rst_n, o_valid && (r_idx > r_job.last))

endmodule

// ===== sv/utf8_text_cleaner_top.sv =====
// ---------------------------------------------------------------------------
// UTF-8 text cleaner
// Normalizes whitespace and drops control and format characters in a byte
// stream of UTF-8 text.
// ---------------------------------------------------------------------------
// The input channel takes one raw byte per item, with i_is_final on the last
// byte of a text. The output channel gives one cleaned byte per item; the
// last item caused by an input byte has o_run_end set, and the last item of
// a text has o_text_end set. A text whose final byte yields nothing gives one
// marker item with o_byte_valid low.
// The front end takes one byte per cycle while the job queue has room. Each
// input byte yields zero to five output items, and the back end sends one
// per cycle while the receiver does not stall, so the sustained rate is one
// byte per cycle when each yields at most one item. The first item of a byte
// is offered once its job has passed the queue into the back end's job
// register. When the receiver stalls, the queue fills and o_stall rises
// after DEPTH jobs wait. Reset empties the queue and clears all decode state.
// ---------------------------------------------------------------------------
module utf8_text_cleaner_top
    import utc_pkg::*;
#(
    parameter int FIFO_DEPTH = UTC_FIFO_DEPTH
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_is_final,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_run_end,
    output logic       o_text_end
);

    logic accept, push, pop, full, empty;
    t_job job_in, job_out;

    assign o_stall = full;
    assign accept  = i_valid && !full;

    utc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_in_byte  (i_in_byte),
        .i_is_final (i_is_final),
        .o_push     (push),
        .o_job      (job_in)
    );

    utc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .i_pop   (pop),
        .o_data  (job_out),
        .o_full  (full),
        .o_empty (empty)
    );

    utc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_job        (job_out),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_run_end    (o_run_end),
        .o_text_end   (o_text_end)
    );

endmodule

// ===== verif/utf8_clean_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// UTF-8 text cleaner checker
// Watches both channels of the cleaner. Every accepted input byte is run
// through a local model of the decoder, the whitespace folding and the
// re-encoder. The expected output items are queued, and each accepted output
// item is compared field by field with the oldest one.
// ---------------------------------------------------------------------------
module utf8_clean_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_final,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_out_byte,
    input  logic       i_out_byte_valid,
    input  logic       i_out_run_end,
    input  logic       i_out_text_end,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);

    localparam logic [7:0] ASCII_SPACE = 8'h20;

    typedef struct packed {
        logic [7:0] data;
        logic       bv;
        logic       run_end;
        logic       text_end;
    } t_clean_item;

    t_clean_item cleaned_q [$];

    logic [1:0]  cont_left;
    logic [20:0] partial_cp;
    logic        ws_pending;
    logic        ws_has_break;
    logic        last_cjk;
    logic        any_kept;

    function automatic logic between(logic [20:0] c, logic [20:0] lo, logic [20:0] hi);
        return (c >= lo) && (c <= hi);
    endfunction

    function automatic logic is_space_cp(logic [20:0] c);
        return c == 21'h20 || between(c, 21'h09, 21'h0D) || between(c, 21'h1C, 21'h1E) ||
               c == 21'h85 || c == 21'hA0 || c == 21'h1680 ||
               between(c, 21'h2000, 21'h200A) || c == 21'h2028 || c == 21'h2029 ||
               c == 21'h202F || c == 21'h205F || c == 21'h3000;
    endfunction

    function automatic logic is_linebreak_cp(logic [20:0] c);
        return between(c, 21'h0A, 21'h0D) || between(c, 21'h1C, 21'h1E) ||
               c == 21'h85 || c == 21'h2028 || c == 21'h2029;
    endfunction

    function automatic logic is_stripped_cp(logic [20:0] c);
        return c <= 21'h1F || between(c, 21'h7F, 21'h9F) ||
               between(c, 21'hD800, 21'hDFFF) ||
               between(c, 21'hE000, 21'hF8FF) || between(c, 21'hF0000, 21'hFFFFD) ||
               between(c, 21'h100000, 21'h10FFFD) ||
               c == 21'hAD || between(c, 21'h200B, 21'h200F) || c == 21'hFEFF;
    endfunction

    function automatic logic is_cjk_cp(logic [20:0] c);
        return between(c, 21'h1100, 21'h11FF) || between(c, 21'h2E80, 21'h2FDF) ||
               between(c, 21'h3000, 21'h31FF) || between(c, 21'h3400, 21'h4DBF) ||
               between(c, 21'h4E00, 21'h9FFF) || between(c, 21'hA960, 21'hA97F) ||
               between(c, 21'hAC00, 21'hD7A3) || between(c, 21'hD7B0, 21'hD7FF) ||
               between(c, 21'hF900, 21'hFAFF) || between(c, 21'hFE30, 21'hFE4F) ||
               between(c, 21'hFF01, 21'hFF9F) || between(c, 21'h20000, 21'h2FA1F);
    endfunction

    task automatic clear_text_state();
        cont_left    = 2'd0;
        partial_cp   = '0;
        ws_pending   = 1'b0;
        ws_has_break = 1'b0;
        last_cjk     = 1'b0;
        any_kept     = 1'b0;
    endtask

    task automatic clean_byte(input logic [7:0] b, input logic fin);
        logic [20:0] cp;
        logic        have;
        logic        cjk;
        logic [7:0]  emit [5];
        int          n;
        int          k;
        t_clean_item item;
        cp   = '0;
        have = 1'b0;
        n    = 0;
        if (cont_left == 2'd0) begin
            if (b[7] == 1'b0) begin
                cp   = {13'd0, b};
                have = 1'b1;
            end else if (b[7:5] == 3'b110) begin
                partial_cp = {16'd0, b[4:0]};
                cont_left  = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                partial_cp = {17'd0, b[3:0]};
                cont_left  = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                partial_cp = {18'd0, b[2:0]};
                cont_left  = 2'd3;
            end
        end else begin
            partial_cp = {partial_cp[14:0], b[5:0]};
            cont_left  = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
                cp   = partial_cp;
                have = 1'b1;
            end
        end
        if (have) begin
            if (is_space_cp(cp)) begin
                if (any_kept) begin
                    ws_pending = 1'b1;
                    if (is_linebreak_cp(cp)) begin
                        ws_has_break = 1'b1;
                    end
                end
            end else if (!is_stripped_cp(cp)) begin
                cjk = is_cjk_cp(cp);
                if (ws_pending && !(ws_has_break && last_cjk && cjk)) begin
                    emit[n] = ASCII_SPACE;
                    n++;
                end
                if (cp <= 21'h7F) begin
                    emit[n] = cp[7:0];
                    n++;
                end else if (cp <= 21'h7FF) begin
                    emit[n]   = {3'b110, cp[10:6]};
                    emit[n+1] = {2'b10, cp[5:0]};
                    n += 2;
                end else if (cp <= 21'hFFFF) begin
                    emit[n]   = {4'b1110, cp[15:12]};
                    emit[n+1] = {2'b10, cp[11:6]};
                    emit[n+2] = {2'b10, cp[5:0]};
                    n += 3;
                end else if (cp <= 21'h10FFFF) begin
                    emit[n]   = {5'b11110, cp[20:18]};
                    emit[n+1] = {2'b10, cp[17:12]};
                    emit[n+2] = {2'b10, cp[11:6]};
                    emit[n+3] = {2'b10, cp[5:0]};
                    n += 4;
                end
                last_cjk     = cjk;
                any_kept     = 1'b1;
                ws_pending   = 1'b0;
                ws_has_break = 1'b0;
            end
        end
        for (k = 0; k < n; k++) begin
            item.data     = emit[k];
            item.bv       = 1'b1;
            item.run_end  = (k == n - 1);
            item.text_end = (k == n - 1) && fin;
            cleaned_q.push_back(item);
        end
        if (fin) begin
            if (n == 0) begin
                item.data     = 8'h00;
                item.bv       = 1'b0;
                item.run_end  = 1'b1;
                item.text_end = 1'b1;
                cleaned_q.push_back(item);
            end
            clear_text_state();
        end
    endtask

    task automatic compare_item();
        t_clean_item want;
        if (cleaned_q.size() == 0) begin
            $error("unexpected output item: out_byte %02h byte_valid %0b", i_out_byte,
                   i_out_byte_valid);
            o_fail_count++;
        end else begin
            want = cleaned_q.pop_front();
            o_checked++;
            if (i_out_byte !== want.data) begin
                $error("out_byte: expected %02h, actual %02h", want.data, i_out_byte);
                o_fail_count++;
            end
            if (i_out_byte_valid !== want.bv) begin
                $error("byte_valid: expected %0b, actual %0b", want.bv, i_out_byte_valid);
                o_fail_count++;
            end
            if (i_out_run_end !== want.run_end) begin
                $error("run_end: expected %0b, actual %0b", want.run_end, i_out_run_end);
                o_fail_count++;
            end
            if (i_out_text_end !== want.text_end) begin
                $error("text_end: expected %0b, actual %0b", want.text_end, i_out_text_end);
                o_fail_count++;
            end
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_checked    = 0;
        o_pending    = 0;
        clear_text_state();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_text_state();
            cleaned_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                clean_byte(i_in_byte, i_in_final);
            end
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                compare_item();
            end
        end
        o_pending = cleaned_q.size();
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// UTF-8 text cleaner testbench
// Drives short texts of UTF-8 bytes into the cleaner: a directed pair of
// texts first, then random texts that are mostly well formed with some
// stray, truncated and corrupted sequences. Both channels idle at random.
// The checker beside the block predicts and compares every output item.
// ---------------------------------------------------------------------------
module tb;

    localparam int TOTAL_ITEMS = 450;
    localparam int CYCLE_LIMIT = 200000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_in_byte;
    logic       i_is_final;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic       o_run_end;
    logic       o_text_end;

    int fail_count;
    int pending;
    int checked;
    int bytes_sent;
    int texts_sent;
    int cycle_count;
    logic send_burst;

    logic [7:0] text_bytes [$];

    utf8_text_cleaner_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_in_byte    (i_in_byte),
        .i_is_final   (i_is_final),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_run_end    (o_run_end),
        .o_text_end   (o_text_end)
    );

    utf8_clean_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_in_byte        (i_in_byte),
        .i_in_final       (i_is_final),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_out_byte       (o_out_byte),
        .i_out_byte_valid (o_byte_valid),
        .i_out_run_end    (o_run_end),
        .i_out_text_end   (o_text_end),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Run stopped after %0d cycles with %0d items outstanding.", cycle_count,
                 pending);
        $display("FAIL utf8_text_cleaner_top");
        $finish;
    end

    task automatic send_item(input logic [7:0] b, input logic fin);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_in_byte  <= b;
        i_is_final <= fin;
        forever begin
            @(negedge i_clk);
            if (!o_stall) break;
        end
        @(posedge i_clk);
        bytes_sent++;
        if (fin) texts_sent++;
        if (bytes_sent % 32 == 0) send_burst = ($urandom_range(0, 3) == 0);
    endtask

    task automatic send_text();
        int k;
        for (k = 0; k < text_bytes.size(); k++) begin
            send_item(text_bytes[k], k == text_bytes.size() - 1);
        end
        text_bytes.delete();
    endtask

    function automatic logic [20:0] pick_code();
        case ($urandom_range(0, 17))
            0, 1, 2: return 21'($urandom_range(8'h21, 8'h7E));
            3: begin
                case ($urandom_range(0, 2))
                    0: return 21'h20;
                    1: return 21'($urandom_range(8'h09, 8'h0D));
                    default: return 21'($urandom_range(8'h1C, 8'h1E));
                endcase
            end
            4: begin
                case ($urandom_range(0, 8))
                    0: return 21'h85;
                    1: return 21'hA0;
                    2: return 21'h1680;
                    3: return 21'h2028;
                    4: return 21'h2029;
                    5: return 21'h202F;
                    6: return 21'h205F;
                    7: return 21'h3000;
                    default: return 21'($urandom_range(16'h2000, 16'h200A));
                endcase
            end
            5: begin
                if ($urandom_range(0, 1)) return 21'($urandom_range(0, 8'h1F));
                return 21'($urandom_range(8'h7F, 8'h9F));
            end
            6, 7: begin
                case ($urandom_range(0, 11))
                    0: return 21'($urandom_range(16'h1100, 16'h11FF));
                    1: return 21'($urandom_range(16'h2E80, 16'h2FDF));
                    2: return 21'($urandom_range(16'h3000, 16'h31FF));
                    3: return 21'($urandom_range(16'h3400, 16'h4DBF));
                    4: return 21'($urandom_range(16'h4E00, 16'h9FFF));
                    5: return 21'($urandom_range(16'hA960, 16'hA97F));
                    6: return 21'($urandom_range(16'hAC00, 16'hD7A3));
                    7: return 21'($urandom_range(16'hD7B0, 16'hD7FF));
                    8: return 21'($urandom_range(16'hF900, 16'hFAFF));
                    9: return 21'($urandom_range(16'hFE30, 16'hFE4F));
                    10: return 21'($urandom_range(16'hFF01, 16'hFF9F));
                    default: return 21'($urandom_range(20'h20000, 20'h2FA1F));
                endcase
            end
            8: begin
                case ($urandom_range(0, 2))
                    0: return 21'hAD;
                    1: return 21'hFEFF;
                    default: return 21'($urandom_range(16'h200B, 16'h200F));
                endcase
            end
            9: return 21'($urandom_range(16'hD800, 16'hDFFF));
            10: begin
                case ($urandom_range(0, 2))
                    0: return 21'($urandom_range(16'hE000, 16'hF8FF));
                    1: return 21'($urandom_range(20'hF0000, 20'hFFFFD));
                    default: return 21'($urandom_range(21'h100000, 21'h10FFFD));
                endcase
            end
            11: return 21'($urandom_range(8'h80, 16'h7FF));
            12: return 21'($urandom_range(16'h800, 16'hFFFF));
            13: return 21'($urandom_range(20'h10000, 21'h10FFFF));
            14: return 21'($urandom_range(21'h110000, 21'h1FFFFF));
            15: begin
                case ($urandom_range(0, 11))
                    0: return 21'h10FFFE;
                    1: return 21'h10FFFF;
                    2: return 21'h10FFFD;
                    3: return 21'h2FA1F;
                    4: return 21'h2FA20;
                    5: return 21'hFFFF;
                    6: return 21'h7FF;
                    7: return 21'h800;
                    8: return 21'h7F;
                    9: return 21'h1FFFFF;
                    10: return 21'h20000;
                    default: return 21'hFFFD;
                endcase
            end
            16: return 21'h20;
            default: return 21'h0A;
        endcase
    endfunction

    // Mode 0 is a clean sequence, 1 a truncated one, 2 corrupts any last trail byte.
    task automatic add_code(input logic [20:0] cp, input int mode);
        logic [7:0] enc [4];
        int         len;
        int         k;
        if (cp <= 21'h7F) begin
            enc[0] = cp[7:0];
            len    = 1;
        end else if (cp <= 21'h7FF) begin
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
            len    = 2;
        end else if (cp <= 21'hFFFF) begin
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
            len    = 3;
        end else begin
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
            len    = 4;
        end
        if (mode == 1) begin
            if (len == 1) begin
                enc[0] = 8'($urandom_range(8'hC0, 8'hF7));
            end else begin
                len--;
            end
        end else if (mode == 2 && len > 1) begin
            enc[len-1] = 8'($urandom_range(0, 255));
        end
        for (k = 0; k < len; k++) text_bytes.push_back(enc[k]);
    endtask

    task automatic build_text();
        int n;
        int k;
        int r;
        n = $urandom_range(1, 12);
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 19);
            if (r == 0) begin
                text_bytes.push_back(8'($urandom_range(0, 255)));
            end else if (r == 1) begin
                add_code(pick_code(), 1);
            end else if (r == 2) begin
                add_code(pick_code(), 2);
            end else begin
                add_code(pick_code(), 0);
            end
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_in_byte  <= 8'h00;
        i_is_final <= 1'b0;
        bytes_sent = 0;
        texts_sent = 0;
        send_burst = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A run with no line break between two CJK characters still folds to a space,
        // and an out-of-range point still takes a space before it.
        text_bytes = '{8'h41, 8'h09, 8'h7F, 8'h42, 8'hFF, 8'h0A,
                       8'hE4, 8'hB8, 8'h80, 8'hE3, 8'h80, 8'h80, 8'hE4, 8'hBA, 8'h8C,
                       8'h20, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
                       8'h20, 8'hF7, 8'hBF, 8'hBF, 8'hBF};
        send_text();
        // Leading and trailing runs vanish and the cut-off lead leaves a bare end marker.
        text_bytes = '{8'h20, 8'h41, 8'h0A, 8'hC2};
        send_text();

        while (bytes_sent < TOTAL_ITEMS) begin
            build_text();
            send_text();
        end
        i_valid <= 1'b0;

        do @(negedge i_clk); while (pending != 0);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d bytes in %0d texts and checked %0d output items.", bytes_sent,
                 texts_sent, checked);
        $display("Texts mixed whitespace, CJK, stripped and out-of-range points with noise.");
        if (fail_count == 0) begin
            $display("PASS utf8_text_cleaner_top");
        end else begin
            $display("FAIL utf8_text_cleaner_top");
        end
        $finish;
    end

    initial begin
        int   stall_len;
        int   recv_count;
        logic recv_burst;
        recv_count = 0;
        recv_burst = 1'b0;
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall_len = recv_burst ? 0 : $urandom_range(0, 9);
            if (stall_len > 0) begin
                i_stall <= 1'b1;
                repeat (stall_len) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            forever begin
                @(negedge i_clk);
                if (o_valid) break;
            end
            @(posedge i_clk);
            recv_count++;
            if (recv_count % 32 == 0) recv_burst = ($urandom_range(0, 3) == 0);
        end
    end

endmodule
